// ----- design/sttf_pkg.sv -----
`default_nettype none

package sttf_pkg;

   localparam int KEY_W    = 31;
   localparam int IDENT_W  = 32;
   localparam int GEN_W    = 64;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 6;
   localparam int USED_W   = 7;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED   = 2'd0,
      ST_APPENDED = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_ERROR    = 2'd3
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [IDENT_W-1:0] ident;
      logic [GEN_W-1:0]   gen;
   } entry_type;

endpackage

`default_nettype wire

// ----- design/sttf_req_if.sv -----
`default_nettype none

interface sttf_req_if;
   import sttf_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [KEY_W-1:0]   key_pid;
   logic [IDENT_W-1:0] entry_id;
   logic [GEN_W-1:0]   entry_genome;

   modport source (output valid, output action, output key_pid, output entry_id,
                   output entry_genome, input ready);
   modport sink   (input valid, input action, input key_pid, input entry_id,
                   input entry_genome, output ready);
endinterface

`default_nettype wire

// ----- design/sttf_rsp_if.sv -----
`default_nettype none

interface sttf_rsp_if;
   import sttf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [USED_W-1:0]   used_slots;

   modport source (output valid, output status, output slot_index, output used_slots,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input used_slots,
                   output ready);
endinterface

`default_nettype wire

// ----- design/sttf_mem.sv -----
`default_nettype none

module sttf_mem #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                               clock,
   input  wire                               wr_en,
   input  wire [$clog2(TABLE_DEPTH)-1:0]     wr_addr,
   input  wire sttf_pkg::entry_type          wr_data,
   input  wire                               rd_en,
   input  wire [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
   output sttf_pkg::entry_type               rd_data
);
   import sttf_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/sttf_ctrl.sv -----
`default_nettype none

module sttf_ctrl #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                           clock,
   input  wire                           reset,
   sttf_req_if.sink                      req_chan,
   sttf_rsp_if.source                    rsp_chan,
   output logic                          mem_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
   output sttf_pkg::entry_type           mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
   input  wire sttf_pkg::entry_type      mem_rd_data
);
   import sttf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_WRITE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   entry_type          word_ff, word_in;
   action_type         act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [USED_W-1:0]  rsp_used_ff, rsp_used_in;

   logic               req_take;
   logic               match;
   logic               out_free;

   assign req_take = req_chan.valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign match    = chk_vld_ff && ((act_ff == ACT_INSERT) ? !mem_rd_data.valid
                                                           : (mem_rd_data.key == key_ff));

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      word_in       = word_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      ident_in      = ident_ff;
      gen_in        = gen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_used_in   = rsp_used_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = slot_ff;
      mem_wr_data   = word_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in   = action_type'(req_chan.action);
               key_in   = req_chan.key_pid;
               ident_in = req_chan.entry_id;
               gen_in   = req_chan.entry_genome;
               issue_in = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            mem_rd_en  = (issue_ff < used_ff) && !match;
            chk_vld_in = mem_rd_en;
            chk_idx_in = issue_ff[IDX_W-1:0];
            if (mem_rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (match) begin
               hit_in   = 1'b1;
               slot_in  = chk_idx_ff;
               word_in  = mem_rd_data;
               state_in = S_WRITE;
            end else if (issue_ff >= used_ff) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ERROR;
               rsp_slot_in   = '0;
               if (act_ff == ACT_INSERT) begin
                  mem_wr_data.valid = 1'b1;
                  mem_wr_data.key   = key_ff;
                  mem_wr_data.ident = ident_ff;
                  mem_wr_data.gen   = gen_ff;
                  if (hit_ff) begin
                     mem_wr_en     = 1'b1;
                     rsp_status_in = ST_REUSED;
                     rsp_slot_in   = SLOT_W'(slot_ff);
                  end else if (used_ff < DEPTH_CNT) begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = used_ff[IDX_W-1:0];
                     used_in       = used_ff + CNT_W'(1);
                     rsp_status_in = ST_APPENDED;
                     rsp_slot_in   = SLOT_W'(used_ff[IDX_W-1:0]);
                  end
               end else if (hit_ff) begin
                  mem_wr_en         = 1'b1;
                  mem_wr_data.valid = 1'b0;
                  rsp_status_in     = ST_REMOVED;
                  rsp_slot_in       = SLOT_W'(slot_ff);
               end
               rsp_used_in = USED_W'(used_in);
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      slot_ff       <= slot_in;
      word_ff       <= word_in;
      act_ff        <= act_in;
      key_ff        <= key_in;
      ident_ff      <= ident_in;
      gen_ff        <= gen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;
   assign rsp_chan.used_slots = rsp_used_ff;

endmodule

`default_nettype wire

// ----- design/slot_table_first_free_insert.sv -----
`default_nettype none

// Slot table with first-fit reuse. An insert request scans the used slots, lowest first, for
// an invalid entry and overwrites it, otherwise it appends at the used count if the table is not
// full; a remove request scans for the first entry whose key matches and clears its valid mark.
// The table sits in a single memory with one read and one write port, and the scan reads one
// entry per cycle. A request that finds no free slot or no matching key gets an error response.
// The block takes one request at a time; a finished response waits in the output register
// while the next request is scanned.

module slot_table_first_free_insert #(
   parameter int TABLE_DEPTH = 64
) (
   input wire          clock,
   input wire          reset,
   sttf_req_if.sink    req_chan,
   sttf_rsp_if.source  rsp_chan
);
   import sttf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   sttf_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sttf_mem #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ----- design/sttf_checker.sv -----
`default_nettype none

module sttf_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire [sttf_pkg::STATUS_W-1:0] rsp_status,
   input wire [sttf_pkg::SLOT_W-1:0]   rsp_slot_index,
   input wire [sttf_pkg::USED_W-1:0]   rsp_used_slots
);
   import sttf_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while the first is in progress");

   a_error_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ERROR) |-> (rsp_slot_index == '0))
      else $error("error response with a non-zero slot");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_APPENDED) |-> (rsp_used_slots != '0))
      else $error("append response with a zero used count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_slot_index) && $stable(rsp_used_slots))
      else $error("stalled response changed");

endmodule

bind slot_table_first_free_insert sttf_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_slot_index (rsp_chan.slot_index),
   .rsp_used_slots (rsp_chan.used_slots)
);

`default_nettype wire

// ----- bench/slot_table_first_free_insert_tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sttf_pkg::*;

   localparam int DEPTH           = 64;
   localparam int RANDOM_REQUESTS = 1880;
   localparam int STALL_LIMIT     = 5000;
   localparam int POOL_SIZE       = 24;
   localparam logic [16:0] TYPED_ROWS = 17'b0_0000_0100_0000_0111;

   typedef struct packed {
      action_type         act;
      logic [KEY_W-1:0]   key;
      logic [IDENT_W-1:0] ident;
      logic [GEN_W-1:0]   gen;
   } request_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [USED_W-1:0] used;
   } answer_type;

   typedef struct packed {
      request_type req;
      answer_type  ans;
   } directed_row_type;

   logic clock;
   logic reset;
   bit   idle_en = 1'b1;
   int   mismatch_cnt = 0;
   int   stall_cnt = 0;

   answer_type       pending_answers[$];
   logic [KEY_W-1:0] slot_key   [DEPTH];
   bit               slot_valid [DEPTH];
   int unsigned      slots_used = 0;
   logic [KEY_W-1:0] key_pool   [POOL_SIZE];

   directed_row_type directed_rows [17] = '{
      '{'{ACT_REMOVE, 31'h0, 32'h0, 64'h0}, '{ST_ERROR, 6'd0, 7'd0}},
      '{'{ACT_INSERT, 31'h7FFFFFFF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF},
        '{ST_APPENDED, 6'd0, 7'd1}},
      '{'{ACT_INSERT, 31'h0, 32'h0, 64'h0}, '{ST_APPENDED, 6'd1, 7'd2}},
      '{'{ACT_INSERT, 31'h2AAAAAAA, 32'hAAAAAAAA, 64'h5555555555555555},
        '{ST_APPENDED, 6'd2, 7'd3}},
      '{'{ACT_REMOVE, 31'h7FFFFFFF, 32'h0, 64'h0}, '{ST_REMOVED, 6'd0, 7'd3}},
      '{'{ACT_REMOVE, 31'h7FFFFFFF, 32'h0, 64'h0}, '{ST_REMOVED, 6'd0, 7'd3}},
      '{'{ACT_REMOVE, 31'h2AAAAAAA, 32'h0, 64'h0}, '{ST_REMOVED, 6'd2, 7'd3}},
      '{'{ACT_INSERT, 31'h55555555, 32'h55555555, 64'hAAAAAAAAAAAAAAAA},
        '{ST_REUSED, 6'd0, 7'd3}},
      '{'{ACT_INSERT, 31'h1, 32'h1, 64'h1}, '{ST_REUSED, 6'd2, 7'd3}},
      '{'{ACT_INSERT, 31'h2, 32'h2, 64'h2}, '{ST_APPENDED, 6'd3, 7'd4}},
      '{'{ACT_REMOVE, 31'h1234567, 32'h0, 64'h0}, '{ST_ERROR, 6'd0, 7'd4}},
      '{'{ACT_REMOVE, 31'h0, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF},
        '{ST_REMOVED, 6'd1, 7'd4}},
      '{'{ACT_REMOVE, 31'h0, 32'h0, 64'h0}, '{ST_REMOVED, 6'd1, 7'd4}},
      '{'{ACT_INSERT, 31'h0, 32'h3, 64'h3}, '{ST_REUSED, 6'd1, 7'd4}},
      '{'{ACT_INSERT, 31'h2, 32'h4, 64'h4}, '{ST_APPENDED, 6'd4, 7'd5}},
      '{'{ACT_REMOVE, 31'h2, 32'h0, 64'h0}, '{ST_REMOVED, 6'd3, 7'd5}},
      '{'{ACT_REMOVE, 31'h2, 32'h0, 64'h0}, '{ST_REMOVED, 6'd3, 7'd5}}
   };

   sttf_req_if req_bus ();
   sttf_rsp_if rsp_bus ();

   slot_table_first_free_insert #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic answer_type predict_table_op(input request_type r);
      answer_type a;
      int         hit;
      a.status = ST_ERROR;
      a.slot   = '0;
      hit      = -1;
      for (int i = 0; i < slots_used; i++) begin
         if (hit < 0 && ((r.act == ACT_INSERT && !slot_valid[i]) ||
                         (r.act == ACT_REMOVE && slot_key[i] == r.key))) begin
            hit = i;
         end
      end
      if (r.act == ACT_INSERT) begin
         if (hit >= 0) begin
            a.status = ST_REUSED;
         end else if (slots_used < DEPTH) begin
            hit = slots_used;
            slots_used++;
            a.status = ST_APPENDED;
         end
         if (hit >= 0) begin
            slot_key[hit]   = r.key;
            slot_valid[hit] = 1'b1;
         end
      end else if (hit >= 0) begin
         slot_valid[hit] = 1'b0;
         a.status = ST_REMOVED;
      end
      if (hit >= 0) begin
         a.slot = hit[SLOT_W-1:0];
      end
      a.used = slots_used[USED_W-1:0];
      return a;
   endfunction

   task automatic push_request(input request_type r);
      if (idle_en && $urandom_range(99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 32) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= r.act;
      req_bus.key_pid      <= r.key;
      req_bus.entry_id     <= r.ident;
      req_bus.entry_genome <= r.gen;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic check_answer();
      answer_type want;
      if (pending_answers.size() == 0) begin
         if (mismatch_cnt < 10) begin
            $display("%0t: unexpected response status %0d slot %0d used %0d", $realtime,
                     rsp_bus.status, rsp_bus.slot_index, rsp_bus.used_slots);
         end
         mismatch_cnt++;
      end else begin
         want = pending_answers.pop_front();
         if (rsp_bus.status !== want.status || rsp_bus.slot_index !== want.slot ||
             rsp_bus.used_slots !== want.used) begin
            if (mismatch_cnt < 10) begin
               $display("%0t: expected status %0d slot %0d used %0d, got %0d %0d %0d",
                        $realtime, want.status, want.slot, want.used, rsp_bus.status,
                        rsp_bus.slot_index, rsp_bus.used_slots);
            end
            mismatch_cnt++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= !idle_en || ($urandom_range(99) >= 32);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         check_answer();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      request_type r;
      answer_type  predicted;
      int          burst_left;
      int          insert_pct;
      int          pick;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_INSERT;
      req_bus.key_pid      = '0;
      req_bus.entry_id     = '0;
      req_bus.entry_genome = '0;
      rsp_bus.ready        = 1'b0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         key_pool[i] = KEY_W'($urandom);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         push_request(directed_rows[n].req);
         predicted = predict_table_op(directed_rows[n].req);
         pending_answers.push_back(TYPED_ROWS[n] ? directed_rows[n].ans : predicted);
      end

      // The first burst is insert-heavy so that the table fills up early.
      burst_left = 100;
      insert_pct = 90;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(80, 20);
            case ($urandom_range(2))
               0: insert_pct = 90;
               1: insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         burst_left--;
         idle_en = !(n >= 900 && n < 1200);
         if (n == 600 || n == 1300) begin
            drain_results();
         end
         r.act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
         pick  = $urandom_range(99);
         if (pick < 6) begin
            key_pool[$urandom_range(POOL_SIZE - 1)] = KEY_W'($urandom);
         end
         r.key   = (pick < 15) ? KEY_W'($urandom) : key_pool[$urandom_range(POOL_SIZE - 1)];
         r.ident = $urandom;
         r.gen   = {$urandom, $urandom};
         push_request(r);
         pending_answers.push_back(predict_table_op(r));
      end

      drain_results();
      repeat (80) @(posedge clock);
      if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/sttf_pkg.sv
design/sttf_req_if.sv
design/sttf_rsp_if.sv
design/sttf_mem.sv
design/sttf_ctrl.sv
design/slot_table_first_free_insert.sv
design/sttf_checker.sv
bench/slot_table_first_free_insert_tb.sv
